FILE: rtl/acpt_pkg.sv
`timescale 1ns / 1ps
package acpt_pkg;

    localparam int LAYER_ROWS = 8;
    localparam int LAYER_W    = 3;
    localparam int ROW_W      = 8;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_BEGIN = 2'd1,
        EV_STAY  = 2'd2,
        EV_END   = 2'd3
    } event_t;

endpackage

FILE: rtl/aabb_collision_pair_tracker.sv
`timescale 1ns / 1ps
// Collider pair contact tracker.
// Input channel (in_valid/in_ready) takes one candidate pair per request: two IDs,
// a packed layer pair, two box centres and sizes and the dead flags. Output
// channel (out_valid/out_ready) returns one result per request: event_res
// (none, begin, stay, end) and the geometric overlap bit, zero for a filtered pair.
// Configuration: cfg_wr_en with cfg_index selects one of eight layer rows;
// the write lands at the same clock edge. Write only while no request is in flight.
// Path: an accepted request passes the stage-1 registers (with the pair store read),
// then the output registers. Throughput: one request per cycle while the output is
// not stalled and the reset sweep is done, set by the read-modify-write of the one-bit
// pair store, with the previous write forwarded to a read of the same pair.
// Reset: the pair store is swept to zero entry by entry, all MAX_COLLIDERS*MAX_COLLIDERS
// bits (4096 at the default), with in_ready low; layer rows reset to zero.
// Stall: with out_ready low the result holds; one more request is taken and
// parked in the pipeline register, then in_ready drops until the output drains.
module aabb_collision_pair_tracker
    import acpt_pkg::*;
#(
    parameter int MAX_COLLIDERS = 64,
    parameter int NUM_LAYERS    = 8,
    parameter int COORD_BITS    = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [ROW_W-1:0]             cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [$clog2(MAX_COLLIDERS)-1:0] first_id,
    input  logic [$clog2(MAX_COLLIDERS)-1:0] second_id,
    input  logic [2*LAYER_W-1:0]         layer_pair,
    input  logic signed [COORD_BITS-1:0] first_x,
    input  logic signed [COORD_BITS-1:0] first_y,
    input  logic [COORD_BITS-2:0]        first_w,
    input  logic [COORD_BITS-2:0]        first_h,
    input  logic signed [COORD_BITS-1:0] second_x,
    input  logic signed [COORD_BITS-1:0] second_y,
    input  logic [COORD_BITS-2:0]        second_w,
    input  logic [COORD_BITS-2:0]        second_h,
    input  logic [1:0]                   dead_flags,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   event_res,
    output logic                         overlapping
);

    localparam int ID_W   = $clog2(MAX_COLLIDERS);
    localparam int DEPTH  = MAX_COLLIDERS * MAX_COLLIDERS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ID_W:0]    ID_LIMIT    = (ID_W + 1)'(MAX_COLLIDERS);
    localparam logic [LAYER_W:0] LAYER_LIMIT = (LAYER_W + 1)'(NUM_LAYERS);

    logic [ROW_W-1:0] layer_row_reg [LAYER_ROWS];

    logic [LAYER_W-1:0]  la;
    logic [LAYER_W-1:0]  lb;
    logic [LAYER_W-1:0]  row_sel;
    logic [LAYER_W-1:0]  col_sel;
    logic                layer_ok;
    logic                id_ok;
    logic                skip_s0;
    logic [ADDR_W-1:0]   addr_s0;
    logic signed [COORD_BITS:0] dx_s0;
    logic signed [COORD_BITS:0] dy_s0;
    logic [COORD_BITS-1:0] sw_s0;
    logic [COORD_BITS-1:0] sh_s0;

    logic                s1_valid_reg;
    logic                s1_skip_reg;
    logic                s1_dead_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic signed [COORD_BITS:0] s1_dx_reg;
    logic signed [COORD_BITS:0] s1_dy_reg;
    logic [COORD_BITS-1:0] s1_sw_reg;
    logic [COORD_BITS-1:0] s1_sh_reg;
    logic                fwd_hit_reg;
    logic                fwd_bit_reg;

    logic                out_valid_reg;
    event_t              event_reg;
    logic                overlapping_reg;

    logic                accept;
    logic                advance;
    logic                clr_busy;
    logic                rd_bit;
    logic                prev;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic                touch_x;
    logic                touch_y;
    logic                ov;
    event_t              ev;
    logic                wr_en;
    logic                new_bit;

    // layer matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAYER_ROWS; i++)
            begin
                layer_row_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            layer_row_reg[cfg_index] <= cfg_data;
        end
    end

    // entry stage: filter, address, axis differences
    assign la      = layer_pair[2*LAYER_W-1:LAYER_W];
    assign lb      = layer_pair[LAYER_W-1:0];
    assign row_sel = (la < lb) ? la : lb;
    assign col_sel = (la < lb) ? lb : la;
    assign layer_ok = ({1'b0, col_sel} < LAYER_LIMIT) && layer_row_reg[row_sel][col_sel];
    assign id_ok    = (first_id != second_id)
                   && ({1'b0, first_id} < ID_LIMIT)
                   && ({1'b0, second_id} < ID_LIMIT);
    assign skip_s0  = !(layer_ok && id_ok);
    assign addr_s0  = ADDR_W'(first_id) * ADDR_W'(MAX_COLLIDERS) + ADDR_W'(second_id);
    assign dx_s0    = {first_x[COORD_BITS-1], first_x} - {second_x[COORD_BITS-1], second_x};
    assign dy_s0    = {first_y[COORD_BITS-1], first_y} - {second_y[COORD_BITS-1], second_y};
    assign sw_s0    = {1'b0, first_w} + {1'b0, second_w};
    assign sh_s0    = {1'b0, first_h} + {1'b0, second_h};

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clr_busy && (!s1_valid_reg || advance);
    assign accept   = in_valid && in_ready;

    acpt_pair_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_pair_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (addr_s0),
        .rd_bit  (rd_bit),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_bit  (new_bit),
        .busy    (clr_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // hold payload and forward a same-pair write that lands with the read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_skip_reg <= skip_s0;
            s1_dead_reg <= |dead_flags;
            s1_addr_reg <= addr_s0;
            s1_dx_reg   <= dx_s0;
            s1_dy_reg   <= dy_s0;
            s1_sw_reg   <= sw_s0;
            s1_sh_reg   <= sh_s0;
            fwd_hit_reg <= wr_en && (s1_addr_reg == addr_s0);
            fwd_bit_reg <= new_bit;
        end
    end

    // result stage: overlap test and pair bit update
    assign prev    = fwd_hit_reg ? fwd_bit_reg : rd_bit;
    assign ax      = s1_dx_reg[COORD_BITS] ? COORD_BITS'(-s1_dx_reg) : COORD_BITS'(s1_dx_reg);
    assign ay      = s1_dy_reg[COORD_BITS] ? COORD_BITS'(-s1_dy_reg) : COORD_BITS'(s1_dy_reg);
    assign touch_x = {ax, 1'b0} <= {1'b0, s1_sw_reg};
    assign touch_y = {ay, 1'b0} <= {1'b0, s1_sh_reg};
    assign ov      = touch_x && touch_y;
    assign new_bit = ov && (prev || !s1_dead_reg);
    assign wr_en   = advance && !s1_skip_reg;

    always_comb
    begin
        ev = EV_NONE;
        if (!s1_skip_reg)
        begin
            if (ov)
            begin
                if (prev)
                begin
                    ev = s1_dead_reg ? EV_END : EV_STAY;
                end
                else if (!s1_dead_reg)
                begin
                    ev = EV_BEGIN;
                end
            end
            else if (prev)
            begin
                ev = EV_END;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg       <= ev;
            overlapping_reg <= ov && !s1_skip_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = event_reg;
    assign overlapping = overlapping_reg;

endmodule

FILE: rtl/acpt_pair_mem.sv
`timescale 1ns / 1ps
module acpt_pair_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_bit,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_bit,
    output logic              busy
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic              mem [DEPTH];
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic              rd_bit_reg;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // sweep the store to zero after reset, then take pair updates
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= 1'b0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_bit_reg <= mem[rd_addr];
        end
    end

    assign rd_bit = rd_bit_reg;
    assign busy   = clr_busy_reg;

endmodule

FILE: tb/acpt_pair_checker.sv
`timescale 1ns / 1ps
module acpt_pair_checker
    import acpt_pkg::*;
#(
    parameter int ID_W       = 6,
    parameter int COORD_BITS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [ROW_W-1:0]             cfg_data,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [ID_W-1:0]              first_id,
    input  logic [ID_W-1:0]              second_id,
    input  logic [2*LAYER_W-1:0]         layer_pair,
    input  logic signed [COORD_BITS-1:0] first_x,
    input  logic signed [COORD_BITS-1:0] first_y,
    input  logic [COORD_BITS-2:0]        first_w,
    input  logic [COORD_BITS-2:0]        first_h,
    input  logic signed [COORD_BITS-1:0] second_x,
    input  logic signed [COORD_BITS-1:0] second_y,
    input  logic [COORD_BITS-2:0]        second_w,
    input  logic [COORD_BITS-2:0]        second_h,
    input  logic [1:0]                   dead_flags,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [1:0]                   event_res,
    input  logic                         overlapping,
    output int                           fail_count,
    output int                           pending
);

    typedef struct packed {
        event_t ev;
        logic   ov;
    } contact_t;

    logic [ROW_W-1:0] allow_row [LAYER_ROWS];
    logic             touching [2**(2*ID_W)];
    contact_t         contact_q [$];

    function automatic logic axis_touch(input logic signed [COORD_BITS-1:0] ca,
                                        input logic [COORD_BITS-2:0] sa,
                                        input logic signed [COORD_BITS-1:0] cb,
                                        input logic [COORD_BITS-2:0] sb);
        longint gap;
        gap = longint'(ca) - longint'(cb);
        if (gap < 0)
            gap = -gap;
        return (2 * gap) <= (longint'(sa) + longint'(sb));
    endfunction

    function automatic contact_t predict_contact();
        logic [LAYER_W-1:0] la;
        logic [LAYER_W-1:0] lb;
        logic [LAYER_W-1:0] lo;
        logic [LAYER_W-1:0] hi;
        logic [2*ID_W-1:0]  slot;
        logic               ov;
        logic               was;
        logic               live;
        contact_t           res;
        res = '{ev: EV_NONE, ov: 1'b0};
        la = layer_pair[2*LAYER_W-1:LAYER_W];
        lb = layer_pair[LAYER_W-1:0];
        lo = (la < lb) ? la : lb;
        hi = (la < lb) ? lb : la;
        if (first_id == second_id || !allow_row[lo][hi])
            return res;
        ov = axis_touch(first_x, first_w, second_x, second_w) &&
             axis_touch(first_y, first_h, second_y, second_h);
        slot = {first_id, second_id};
        was  = touching[slot];
        live = (dead_flags == 2'b00);
        res.ov = ov;
        if (ov && was) begin
            res.ev = live ? EV_STAY : EV_END;
        end
        else if (ov && live) begin
            res.ev = EV_BEGIN;
            touching[slot] = 1'b1;
        end
        else if (!ov && was) begin
            res.ev = EV_END;
            touching[slot] = 1'b0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        contact_t want;
        if (!rst_n)
        begin
            foreach (touching[i])
                touching[i] = 1'b0;
            foreach (allow_row[i])
                allow_row[i] = '0;
            contact_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
                allow_row[cfg_index] = cfg_data;
            if (out_valid && out_ready)
            begin
                if (contact_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with none expected: event_res %0d overlapping %0d",
                             $time, event_res, overlapping);
                end
                else
                begin
                    want = contact_q.pop_front();
                    if (event_res !== want.ev)
                    begin
                        fail_count++;
                        $display("%0t: event_res expected %0d, got %0d",
                                 $time, want.ev, event_res);
                    end
                    if (overlapping !== want.ov)
                    begin
                        fail_count++;
                        $display("%0t: overlapping expected %0d, got %0d",
                                 $time, want.ov, overlapping);
                    end
                end
            end
            if (in_valid && in_ready)
                contact_q.push_back(predict_contact());
            pending = contact_q.size();
        end
    end

endmodule

FILE: tb/tb_aabb_collision_pair_tracker.sv
`timescale 1ns / 1ps
module tb_aabb_collision_pair_tracker
    import acpt_pkg::*;
;

    localparam int ID_W        = 6;
    localparam int COORD_BITS  = 20;
    localparam int SZ_W        = COORD_BITS - 1;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [ID_W-1:0]              id_a;
        logic [ID_W-1:0]              id_b;
        logic [2*LAYER_W-1:0]         layers;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic [SZ_W-1:0]              aw;
        logic [SZ_W-1:0]              ah;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic [SZ_W-1:0]              bw;
        logic [SZ_W-1:0]              bh;
        logic [1:0]                   dead;
    } pair_req_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] ca;
        logic [SZ_W-1:0]              sa;
        logic signed [COORD_BITS-1:0] cb;
        logic [SZ_W-1:0]              sb;
    } axis_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [ROW_W-1:0]             cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    logic [ID_W-1:0]              first_id;
    logic [ID_W-1:0]              second_id;
    logic [2*LAYER_W-1:0]         layer_pair;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic [SZ_W-1:0]              first_w;
    logic [SZ_W-1:0]              first_h;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic [SZ_W-1:0]              second_w;
    logic [SZ_W-1:0]              second_h;
    logic [1:0]                   dead_flags;
    logic                         out_valid;
    logic                         out_ready;
    logic [1:0]                   event_res;
    logic                         overlapping;
    int                           fail_count;
    int                           pending;
    int                           idle_pct;
    int                           stall_pct;
    int                           quiet;

    aabb_collision_pair_tracker dut (.*);

    acpt_pair_checker #(.ID_W(ID_W), .COORD_BITS(COORD_BITS)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT)
            begin
                $display("aabb_collision_pair_tracker verification failed");
                $finish;
            end
        end
    end

    function automatic pair_req_t pair_of(input int id_a, input int id_b, input int layers,
                                          input int ax, input int ay, input int aw,
                                          input int ah, input int bx, input int by,
                                          input int bw, input int bh, input int dead);
        pair_req_t p;
        p.id_a   = ID_W'(id_a);
        p.id_b   = ID_W'(id_b);
        p.layers = (2*LAYER_W)'(layers);
        p.ax     = COORD_BITS'(ax);
        p.ay     = COORD_BITS'(ay);
        p.aw     = SZ_W'(aw);
        p.ah     = SZ_W'(ah);
        p.bx     = COORD_BITS'(bx);
        p.by     = COORD_BITS'(by);
        p.bw     = SZ_W'(bw);
        p.bh     = SZ_W'(bh);
        p.dead   = 2'(dead);
        return p;
    endfunction

    // Place two boxes near, inside or well past the touching distance on one axis.
    function automatic axis_t near_axis();
        axis_t a;
        int    span;
        int    twice;
        int    base;
        int    gap;
        case ($urandom_range(2))
            0: span = 63;
            1: span = 4095;
            default: span = 262143;
        endcase
        a.sa  = SZ_W'($urandom_range(span));
        a.sb  = SZ_W'($urandom_range(span));
        twice = int'(a.sa) + int'(a.sb);
        case ($urandom_range(3))
            0, 1: twice = int'($urandom_range(twice));
            2: twice = twice + int'($urandom_range(8)) - 4;
            default: twice = twice + 1 + int'($urandom_range(span));
        endcase
        if (twice < 0)
            twice = 0;
        gap  = twice / 2;
        base = int'($urandom_range(262143)) - 131072;
        a.ca = COORD_BITS'(base);
        a.cb = COORD_BITS'($urandom_range(1) ? base + gap : base - gap);
        return a;
    endfunction

    function automatic pair_req_t rand_pair();
        pair_req_t p;
        axis_t     hx;
        axis_t     vy;
        if ($urandom_range(99) < 15)
        begin
            p.id_a   = ID_W'($urandom);
            p.id_b   = ID_W'($urandom);
            p.layers = (2*LAYER_W)'($urandom);
            p.ax     = COORD_BITS'($urandom);
            p.ay     = COORD_BITS'($urandom);
            p.aw     = SZ_W'($urandom);
            p.ah     = SZ_W'($urandom);
            p.bx     = COORD_BITS'($urandom);
            p.by     = COORD_BITS'($urandom);
            p.bw     = SZ_W'($urandom);
            p.bh     = SZ_W'($urandom);
            p.dead   = 2'($urandom);
            return p;
        end
        if ($urandom_range(9) == 0)
        begin
            p.id_a = ID_W'($urandom);
            p.id_b = ID_W'($urandom);
        end
        else
        begin
            p.id_a = ID_W'($urandom_range(5));
            p.id_b = ID_W'($urandom_range(5));
        end
        p.layers = (2*LAYER_W)'($urandom);
        p.dead   = ($urandom_range(4) == 0) ? 2'($urandom_range(3)) : 2'b00;
        hx = near_axis();
        vy = near_axis();
        p.ax = hx.ca;
        p.aw = hx.sa;
        p.bx = hx.cb;
        p.bw = hx.sb;
        p.ay = vy.ca;
        p.ah = vy.sa;
        p.by = vy.cb;
        p.bh = vy.sb;
        return p;
    endfunction

    task automatic send_pair(input pair_req_t p);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        first_id   <= p.id_a;
        second_id  <= p.id_b;
        layer_pair <= p.layers;
        first_x    <= p.ax;
        first_y    <= p.ay;
        first_w    <= p.aw;
        first_h    <= p.ah;
        second_x   <= p.bx;
        second_y   <= p.by;
        second_w   <= p.bw;
        second_h   <= p.bh;
        dead_flags <= p.dead;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic load_layer_matrix(input logic [ROW_W-1:0] rows [LAYER_ROWS]);
        for (int r = 0; r < LAYER_ROWS; r++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= rows[r];
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        pair_req_t        seed_pairs [$];
        logic [ROW_W-1:0] rows [LAYER_ROWS];
        int               count;

        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        first_id   = '0;
        second_id  = '0;
        layer_pair = '0;
        first_x    = '0;
        first_y    = '0;
        first_w    = '0;
        first_h    = '0;
        second_x   = '0;
        second_y   = '0;
        second_w   = '0;
        second_h   = '0;
        dead_flags = '0;
        out_ready  = 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        quiet      = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (!in_ready)
            @(negedge clk);

        rows = '{8'hFF, 8'hFF, 8'hFF, 8'hDF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        load_layer_matrix(rows);

        seed_pairs.push_back(pair_of(5, 5, 6'o00, 0, 0, 32, 32, 8, 8, 32, 32, 0));
        seed_pairs.push_back(pair_of(1, 2, 6'o00, 0, 0, 32, 32, 8, 8, 32, 32, 0));
        seed_pairs.push_back(pair_of(1, 2, 6'o00, 0, 0, 32, 32, 8, 8, 32, 32, 0));
        seed_pairs.push_back(pair_of(1, 2, 6'o00, 0, 0, 32, 32, 8, 8, 32, 32, 1));
        seed_pairs.push_back(pair_of(1, 2, 6'o00, 0, 0, 32, 32, 8, 8, 32, 32, 0));
        seed_pairs.push_back(pair_of(1, 2, 6'o00, 0, 0, 32, 32, 1000, 8, 32, 32, 3));
        seed_pairs.push_back(pair_of(1, 2, 6'o00, 0, 0, 32, 32, 8, 8, 32, 32, 2));
        seed_pairs.push_back(pair_of(1, 2, 6'o00, 0, 0, 32, 32, 8, 8, 32, 32, 0));
        seed_pairs.push_back(pair_of(2, 1, 6'o00, 0, 0, 32, 32, 8, 8, 32, 32, 0));
        seed_pairs.push_back(pair_of(3, 4, 6'o12, 0, 0, 16, 16, 16, 0, 16, 16, 0));
        seed_pairs.push_back(pair_of(3, 4, 6'o12, 0, 0, 16, 16, 17, 0, 16, 16, 0));
        seed_pairs.push_back(pair_of(63, 0, 6'o06, -524288, 0, 524287, 524287,
                                     524287, 0, 524287, 524287, 0));
        seed_pairs.push_back(pair_of(0, 63, 6'o66, -524288, 524287, 524287, 524287,
                                     -524288, 524287, 524287, 524287, 0));
        seed_pairs.push_back(pair_of(10, 11, 6'o44, 100, -100, 0, 0, 100, -100, 0, 0, 0));
        seed_pairs.push_back(pair_of(10, 11, 6'o44, 100, -100, 0, 0, 101, -100, 0, 0, 0));
        seed_pairs.push_back(pair_of(6, 7, 6'o53, 0, 0, 32, 32, 8, 8, 32, 32, 0));
        seed_pairs.push_back(pair_of(6, 7, 6'o77, 0, 0, 32, 32, 8, 8, 32, 32, 0));
        seed_pairs.push_back(pair_of(6, 7, 6'o70, 0, 0, 32, 32, 8, 8, 32, 32, 0));
        seed_pairs.push_back(pair_of(8, 9, 6'o34, 0, 0, 32, 32, 0, 40, 32, 32, 0));
        foreach (seed_pairs[i])
            send_pair(seed_pairs[i]);

        for (int phase = 0; phase < 8; phase++)
        begin
            drain_results();
            case (phase)
                0, 6: rows = '{default: 8'hFF};
                3: rows = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};
                4: rows = '{default: 8'h00};
                default:
                    foreach (rows[r])
                        rows[r] = ROW_W'($urandom);
            endcase
            load_layer_matrix(rows);
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            count = (phase == 4) ? 40 : 260;
            for (int n = 0; n < count; n++)
            begin
                // hold off until the pipeline is empty once mid-phase
                if (phase == 2 && n == count / 2)
                    drain_results();
                send_pair(rand_pair());
            end
        end

        drain_results();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("aabb_collision_pair_tracker verification clean");
        else
            $display("aabb_collision_pair_tracker verification failed");
        $finish;
    end

endmodule
